// File: rtl/oll_pkg.sv
// Shared types and codes for the ordered list engine.
package oll_pkg;

    // Control fields to the cells are sized for the largest supported depth.
    localparam int CTL_W = 7;

    typedef enum logic [2:0] {
        CMD_INSERT     = 3'd0,
        CMD_APPEND     = 3'd1,
        CMD_REMOVE_POS = 3'd2,
        CMD_REMOVE_VAL = 3'd3,
        CMD_CLEAR      = 3'd4,
        CMD_READ_FWD   = 3'd5,
        CMD_READ_REV   = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_OVERFLOW  = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_INSERT,
        CO_REMOVE,
        CO_COMPARE,
        CO_FOUND_REMOVE,
        CO_ROT_L,
        CO_ROT_R
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [CTL_W-1:0]   pos;
        logic [CTL_W-1:0]   limit;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RD_FWD,
        ST_RESTORE,
        ST_PREP,
        ST_RD_REV
    } t_state;

endpackage

// File: rtl/oll_cell.sv
// One list cell: holds one entry and shifts with its ring neighbors.
module oll_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  oll_pkg::t_cell_ctl    i_ctl,
    input  logic signed [31:0]    i_value,
    input  logic signed [31:0]    i_prev,
    input  logic signed [31:0]    i_next,
    input  logic                  i_found,
    output logic signed [31:0]    o_entry,
    output logic                  o_found
);

    localparam logic [oll_pkg::CTL_W-1:0] IDX_V = oll_pkg::CTL_W'(IDX);

    logic signed [31:0] r_entry;
    logic               r_match;

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            oll_pkg::CO_HOLD: begin
            end
            oll_pkg::CO_INSERT: begin
                if (IDX_V > i_ctl.pos) begin
                    r_entry <= i_prev;
                end else if (IDX_V == i_ctl.pos) begin
                    r_entry <= i_value;
                end
            end
            oll_pkg::CO_REMOVE: begin
                if (IDX_V >= i_ctl.pos) begin
                    r_entry <= i_next;
                end
            end
            oll_pkg::CO_COMPARE: begin
                r_match <= (r_entry == i_value) && (IDX_V < i_ctl.limit);
            end
            oll_pkg::CO_FOUND_REMOVE: begin
                // every cell at or behind the first match pulls from behind
                if (o_found) begin
                    r_entry <= i_next;
                end
            end
            oll_pkg::CO_ROT_L: r_entry <= i_next;
            oll_pkg::CO_ROT_R: r_entry <= i_prev;
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;
    assign o_found = i_found | r_match;

endmodule

// File: rtl/ordered_list_engine.sv
// Ordered list engine: top level with command sequencer and a ring of cells.
// Insert, append, remove at position, clear: one result in the cycle after accept.
// Remove by value: compare step at accept, then shift step in ST_APPLY, then the registered result.
// Read forward: results back to back from ST_RD_FWD, then ST_RESTORE turns the ring back; busy through both.
// Read reverse: ST_PREP pre-rotates the ring, then results back to back from ST_RD_REV; busy through both.
// Empty read: one result in the cycle after accept. No output stall. Sync reset clears count and state.
module ordered_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          i_command,
    input  logic signed [31:0]  i_value,
    input  logic [4:0]          i_position,
    output logic                o_valid,
    output logic signed [31:0]  o_entry_value,
    output logic [2:0]          o_status,
    output logic [4:0]          o_entry_count,
    output logic                o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int W  = oll_pkg::CTL_W;

    oll_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_step, n_step;
    logic               r_valid, n_valid;
    logic signed [31:0] r_res_value, n_res_value;
    logic [2:0]         r_res_status, n_res_status;
    logic [4:0]         r_res_count, n_res_count;
    logic               r_res_last, n_res_last;

    oll_pkg::t_cell_ctl w_ctl;
    logic signed [31:0] w_entry [DEPTH];
    logic               w_found [DEPTH];
    logic               w_accept;
    logic               w_step_last;
    logic               w_full;
    logic [W-1:0]       w_pos;
    logic [W-1:0]       w_cnt;

    assign busy        = (r_state != oll_pkg::ST_IDLE);
    assign w_accept    = start && !busy;
    assign w_step_last = (r_step == r_count - CW'(1));
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_pos       = W'(i_position);
    assign w_cnt       = W'(r_count);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic w_found_in;
        if (g == 0) begin : g_head
            assign w_found_in = 1'b0;
        end else begin : g_body
            assign w_found_in = w_found[g-1];
        end
        oll_cell #(.IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (i_value),
            .i_prev  (w_entry[(g + DEPTH - 1) % DEPTH]),
            .i_next  (w_entry[(g + 1) % DEPTH]),
            .i_found (w_found_in),
            .o_entry (w_entry[g]),
            .o_found (w_found[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_valid      = 1'b0;
        n_res_value  = '0;
        n_res_status = oll_pkg::STS_OK;
        n_res_count  = r_res_count;
        n_res_last   = 1'b1;
        w_ctl.op     = oll_pkg::CO_HOLD;
        w_ctl.pos    = w_pos;
        w_ctl.limit  = w_cnt;

        unique case (r_state)
            oll_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_valid = 1'b1;
                    unique case (i_command)
                        oll_pkg::CMD_INSERT: begin
                            if (w_full) begin
                                n_res_status = oll_pkg::STS_FULL;
                            end else if (w_pos > w_cnt) begin
                                n_res_status = oll_pkg::STS_OVERFLOW;
                            end else begin
                                w_ctl.op = oll_pkg::CO_INSERT;
                                n_count  = r_count + CW'(1);
                            end
                        end
                        oll_pkg::CMD_APPEND: begin
                            if (w_full) begin
                                n_res_status = oll_pkg::STS_FULL;
                            end else begin
                                w_ctl.op  = oll_pkg::CO_INSERT;
                                w_ctl.pos = w_cnt;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        oll_pkg::CMD_REMOVE_POS: begin
                            if (w_pos > w_cnt) begin
                                n_res_status = oll_pkg::STS_OVERFLOW;
                            end else if (w_pos < w_cnt) begin
                                w_ctl.op = oll_pkg::CO_REMOVE;
                                n_count  = r_count - CW'(1);
                            end
                        end
                        oll_pkg::CMD_REMOVE_VAL: begin
                            w_ctl.op = oll_pkg::CO_COMPARE;
                            n_valid  = 1'b0;
                            n_state  = oll_pkg::ST_APPLY;
                        end
                        oll_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        oll_pkg::CMD_READ_FWD, oll_pkg::CMD_READ_REV: begin
                            if (r_count == '0) begin
                                n_res_status = oll_pkg::STS_EMPTY;
                            end else begin
                                n_valid = 1'b0;
                                n_step  = '0;
                                n_state = (i_command == oll_pkg::CMD_READ_FWD) ?
                                          oll_pkg::ST_RD_FWD : oll_pkg::ST_PREP;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_res_count = 5'(n_count);
                end
            end
            oll_pkg::ST_APPLY: begin
                w_ctl.op    = oll_pkg::CO_FOUND_REMOVE;
                n_valid     = 1'b1;
                n_state     = oll_pkg::ST_IDLE;
                if (w_found[DEPTH-1]) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_res_status = oll_pkg::STS_NOT_FOUND;
                end
                n_res_count = 5'(n_count);
            end
            oll_pkg::ST_RD_FWD: begin
                // head cell streams out while the ring turns toward the front
                w_ctl.op    = oll_pkg::CO_ROT_L;
                n_valid     = 1'b1;
                n_res_value = w_entry[0];
                n_res_last  = w_step_last;
                n_res_count = 5'(r_count);
                n_step      = w_step_last ? '0 : r_step + CW'(1);
                if (w_step_last) begin
                    n_state = oll_pkg::ST_RESTORE;
                end
            end
            oll_pkg::ST_RESTORE: begin
                w_ctl.op = oll_pkg::CO_ROT_R;
                n_step   = w_step_last ? '0 : r_step + CW'(1);
                if (w_step_last) begin
                    n_state = oll_pkg::ST_IDLE;
                end
            end
            oll_pkg::ST_PREP: begin
                // bring the tail entry to the top cell
                w_ctl.op = oll_pkg::CO_ROT_L;
                n_step   = w_step_last ? '0 : r_step + CW'(1);
                if (w_step_last) begin
                    n_state = oll_pkg::ST_RD_REV;
                end
            end
            oll_pkg::ST_RD_REV: begin
                w_ctl.op    = oll_pkg::CO_ROT_R;
                n_valid     = 1'b1;
                n_res_value = w_entry[DEPTH-1];
                n_res_last  = w_step_last;
                n_res_count = 5'(r_count);
                n_step      = w_step_last ? '0 : r_step + CW'(1);
                if (w_step_last) begin
                    n_state = oll_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = oll_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= oll_pkg::ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_res_count  <= n_res_count;
        r_res_last   <= n_res_last;
    end

    assign o_valid       = r_valid;
    assign o_entry_value = r_res_value;
    assign o_status      = r_res_status;
    assign o_entry_count = r_res_count;
    assign o_last        = r_res_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_read_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("read beats not contiguous");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_command != oll_pkg::CMD_REMOVE_VAL)
        && (i_command != oll_pkg::CMD_READ_FWD) && (i_command != oll_pkg::CMD_READ_REV)
        |=> o_valid && o_last && !busy)
        else $error("single-beat command missing its result");

    a_no_beat_while_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == oll_pkg::ST_IDLE) && !$past(w_accept) && $past(r_state == oll_pkg::ST_IDLE)
        |-> !o_valid)
        else $error("result beat without a command");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the ordered list engine against a list predictor.
module testbench;

    localparam int DEPTH          = 16;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 340;
    // code with no command behind it; the block must answer it with a plain ok
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
        logic [4:0]         count;
        logic               last;
    } t_list_result;

    class list_scoreboard;
        logic [31:0]  cells [DEPTH];
        int unsigned  count;
        t_list_result pending [$];
        int           mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void expect_result(logic [31:0] v, logic [2:0] st, logic fin);
            t_list_result r;
            r.value  = v;
            r.status = st;
            r.count  = 5'(count);
            r.last   = fin;
            pending.push_back(r);
        endfunction

        function void put_at(int unsigned p, logic [31:0] v);
            int unsigned i;
            for (i = count; i > p; i--)
                cells[i] = cells[i - 1];
            cells[p] = v;
            count++;
        endfunction

        function void drop_at(int unsigned p);
            int unsigned i;
            for (i = p; i + 1 < count; i++)
                cells[i] = cells[i + 1];
            count--;
        endfunction

        // Updates the list for one accepted command and queues the results it causes.
        function void note_command(logic [2:0] c, logic [31:0] v, logic [4:0] p);
            logic [2:0]  st;
            int unsigned i;
            st = oll_pkg::STS_OK;
            case (c)
                oll_pkg::CMD_INSERT: begin
                    if (count >= DEPTH)
                        st = oll_pkg::STS_FULL;
                    else if (p > count)
                        st = oll_pkg::STS_OVERFLOW;
                    else
                        put_at(p, v);
                end
                oll_pkg::CMD_APPEND: begin
                    if (count >= DEPTH)
                        st = oll_pkg::STS_FULL;
                    else
                        put_at(count, v);
                end
                oll_pkg::CMD_REMOVE_POS: begin
                    if (p > count)
                        st = oll_pkg::STS_OVERFLOW;
                    else if (p < count)
                        drop_at(p);
                end
                oll_pkg::CMD_REMOVE_VAL: begin
                    st = oll_pkg::STS_NOT_FOUND;
                    for (i = 0; i < count; i++) begin
                        if (cells[i] == v) begin
                            drop_at(i);
                            st = oll_pkg::STS_OK;
                            break;
                        end
                    end
                end
                oll_pkg::CMD_CLEAR: begin
                    count = 0;
                end
                oll_pkg::CMD_READ_FWD, oll_pkg::CMD_READ_REV: begin
                    if (count == 0) begin
                        expect_result('0, oll_pkg::STS_EMPTY, 1'b1);
                    end else begin
                        for (i = 0; i < count; i++)
                            expect_result(
                                cells[(c == oll_pkg::CMD_READ_FWD) ? i : count - 1 - i],
                                oll_pkg::STS_OK, i + 1 == count);
                    end
                    return;
                end
                default: ;
            endcase
            expect_result('0, st, 1'b1);
        endfunction

        function void check_result(t_list_result got);
            t_list_result want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected beat: value %0d status %0d count %0d last %0b",
                             got.value, got.status, got.count, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.count !== want.count || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"mismatch: expected value %0d status %0d count %0d last %0b,",
                              " got value %0d status %0d count %0d last %0b"},
                             want.value, want.status, want.count, want.last,
                             got.value, got.status, got.count, got.last);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_command = oll_pkg::CMD_CLEAR;
    logic signed [31:0] i_value = '0;
    logic [4:0]         i_position = '0;
    logic               o_valid;
    logic signed [31:0] o_entry_value;
    logic [2:0]         o_status;
    logic [4:0]         o_entry_count;
    logic               o_last;

    list_scoreboard sb = new();
    int             quiet_cycles = 0;

    ordered_list_engine #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .o_entry_value (o_entry_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result check and watchdog; both see the values from before the edge.
    always @(posedge i_clk) begin : monitor
        t_list_result got;
        if (i_rst_n && o_valid) begin
            got.value  = o_entry_value;
            got.status = o_status;
            got.count  = o_entry_count;
            got.last   = o_last;
            sb.check_result(got);
        end
        if ((i_rst_n && start && !busy) || o_valid)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic issue(input logic [2:0] c, input logic [31:0] v, input logic [4:0] p);
        start      <= 1'b1;
        i_command  <= c;
        i_value    <= v;
        i_position <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(c, v, p);
    endtask

    task automatic hold_off(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic issue_gap(input logic [2:0] c, input logic [31:0] v, input logic [4:0] p,
                             input bit no_gaps);
        issue(c, v, p);
        if (!no_gaps)
            hold_off(pick_gap());
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            4, 5:    return $urandom_range(0, 7);  // duplicates for the value search
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] pick_command(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (grow) begin
            if (r < 30) return oll_pkg::CMD_INSERT;
            if (r < 55) return oll_pkg::CMD_APPEND;
            if (r < 65) return oll_pkg::CMD_REMOVE_POS;
            if (r < 73) return oll_pkg::CMD_REMOVE_VAL;
            if (r < 75) return oll_pkg::CMD_CLEAR;
            if (r < 87) return oll_pkg::CMD_READ_FWD;
            if (r < 98) return oll_pkg::CMD_READ_REV;
        end else begin
            if (r < 10) return oll_pkg::CMD_INSERT;
            if (r < 18) return oll_pkg::CMD_APPEND;
            if (r < 50) return oll_pkg::CMD_REMOVE_POS;
            if (r < 77) return oll_pkg::CMD_REMOVE_VAL;
            if (r < 79) return oll_pkg::CMD_CLEAR;
            if (r < 89) return oll_pkg::CMD_READ_FWD;
            if (r < 98) return oll_pkg::CMD_READ_REV;
        end
        return CMD_UNUSED;
    endfunction

    initial begin : stimulus
        logic [2:0]  c;
        logic [31:0] v;
        logic [4:0]  p;
        bit          no_gaps;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list corner cases
        issue_gap(oll_pkg::CMD_READ_FWD, '0, '0, 0);
        issue_gap(oll_pkg::CMD_READ_REV, '0, '0, 0);
        issue_gap(oll_pkg::CMD_REMOVE_POS, '0, 5'd0, 0);
        issue_gap(oll_pkg::CMD_REMOVE_POS, '0, 5'd1, 0);
        issue_gap(oll_pkg::CMD_REMOVE_VAL, 32'd5, '0, 0);
        issue_gap(oll_pkg::CMD_INSERT, 32'd9, 5'd1, 0);
        // build a short list with extreme values
        issue_gap(oll_pkg::CMD_INSERT, 32'h8000_0000, 5'd0, 0);
        issue_gap(oll_pkg::CMD_APPEND, 32'h7fff_ffff, '0, 0);
        issue_gap(oll_pkg::CMD_APPEND, 32'hffff_ffff, '0, 0);
        issue_gap(oll_pkg::CMD_INSERT, 32'h0, 5'd1, 0);
        issue_gap(oll_pkg::CMD_INSERT, 32'h5a5a_a5a5, 5'd16, 0);
        issue_gap(oll_pkg::CMD_READ_FWD, '0, '0, 0);
        issue_gap(oll_pkg::CMD_READ_REV, '0, '0, 0);
        issue_gap(oll_pkg::CMD_REMOVE_VAL, 32'h0, '0, 0);
        issue_gap(oll_pkg::CMD_REMOVE_VAL, 32'd12345, '0, 0);
        issue_gap(oll_pkg::CMD_REMOVE_POS, '0, 5'd3, 0);
        issue_gap(oll_pkg::CMD_REMOVE_POS, '0, 5'd16, 0);
        issue_gap(oll_pkg::CMD_REMOVE_POS, '0, 5'd0, 0);
        issue_gap(CMD_UNUSED, 32'h1234_5678, 5'd31, 0);
        issue_gap(oll_pkg::CMD_READ_REV, '0, '0, 0);
        issue_gap(oll_pkg::CMD_CLEAR, '0, '0, 0);
        issue_gap(oll_pkg::CMD_READ_FWD, '0, '0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 150 || n == 270) begin
                start <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            // growth phases fill the list up to the full case, shrink phases drain it
            c = pick_command((n % 90) < 60);
            v = pick_value();
            if (c == oll_pkg::CMD_REMOVE_VAL && sb.count > 0 && $urandom_range(0, 9) < 7)
                v = sb.cells[$urandom_range(0, sb.count - 1)];
            if ($urandom_range(0, 99) < 85)
                p = 5'($urandom_range(0, sb.count));
            else
                p = 5'($urandom_range(sb.count, DEPTH));
            no_gaps = (n >= 100 && n < 140);
            issue_gap(c, v, p, no_gaps);
        end

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/oll_pkg.sv
rtl/oll_cell.sv
rtl/ordered_list_engine.sv
tb/sv/testbench.sv
